FILE: rtl/rcts_pkg.sv
// shared types and constants of the reference-counted tag set
// depends on nothing; every other file imports it
package rcts_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int TAG_BITS_DEF = 16;

   localparam int REQ_W    = 2;
   localparam int TAG_W    = 16;
   localparam int AMOUNT_W = 8;
   localparam int COUNT_W  = 8;
   localparam int OCC_W    = 5;
   localparam int STATUS_W = 3;

   typedef enum logic [REQ_W-1:0] {
      REQ_ADD    = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_CLEAR  = 2'd2,
      REQ_LOOKUP = 2'd3
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 3'd0,
      ST_FULL   = 3'd1,
      ST_ABSENT = 3'd2,
      ST_OVER   = 3'd3,
      ST_UNDER  = 3'd4
   } status_code_type;

   // command broadcast to every cell of the chain
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOOK,
      OP_ADD,
      OP_SUB,
      OP_DEL,
      OP_APPEND,
      OP_CLEAR
   } cell_op_type;

   typedef struct packed {
      cell_op_type         op;
      logic [COUNT_W-1:0]  amount;
   } cell_cmd_type;

   // what a cell shows to its neighbors and to the control
   typedef struct packed {
      logic                valid;
      logic                hit;
      logic [COUNT_W-1:0]  count;
   } cell_state_type;

endpackage

FILE: rtl/rcts_req_if.sv
// request channel: valid/ready handshake with the request word
// depends on rcts_pkg
interface rcts_req_if import rcts_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [REQ_W-1:0]     req_type;
   logic [TAG_W-1:0]     tag;
   logic [AMOUNT_W-1:0]  amount;

   modport source (output valid, output req_type, output tag, output amount, input ready);
   modport sink   (input valid, input req_type, input tag, input amount, output ready);
endinterface

FILE: rtl/rcts_rsp_if.sv
// response channel: valid/ready handshake with the result word
// depends on rcts_pkg
interface rcts_rsp_if import rcts_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 found;
   logic [COUNT_W-1:0]   ref_count;
   logic [OCC_W-1:0]     occupancy;
   logic [STATUS_W-1:0]  status;

   modport source (output valid, output found, output ref_count, output occupancy,
                   output status, input ready);
   modport sink   (input valid, input found, input ref_count, input occupancy,
                   input status, output ready);
endinterface

FILE: rtl/rcts_cell.sv
// one table entry of the tag set: tag, count, valid and match flag
// depends on rcts_pkg; chained by refcounted_tag_set
module rcts_cell import rcts_pkg::*; #(
   parameter int TW = TAG_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  cell_cmd_type    cmd,
   input  logic [TW-1:0]   cmd_tag,
   input  logic            prev_valid,
   input  logic [TW-1:0]   next_tag,
   input  cell_state_type  next_st,
   input  logic            shift_in,
   output logic            shift_out,
   output logic [TW-1:0]   own_tag,
   output cell_state_type  own_st
);

   logic                valid_ff;
   logic                hit_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [TW-1:0]       tag_ff;
   logic                take_next;

   // once the deleted entry is passed, every later cell moves down one place
   assign take_next = shift_in | (hit_ff & (cmd.op == OP_DEL));
   assign shift_out = take_next;

   assign own_tag      = tag_ff;
   assign own_st.valid = valid_ff;
   assign own_st.hit   = hit_ff;
   assign own_st.count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         case (cmd.op)
            OP_LOOK: begin
               hit_ff <= valid_ff & (tag_ff == cmd_tag);
            end
            OP_ADD: begin
               if (hit_ff) count_ff <= count_ff + cmd.amount;
            end
            OP_SUB: begin
               if (hit_ff) count_ff <= count_ff - cmd.amount;
            end
            OP_DEL: begin
               if (take_next) begin
                  tag_ff   <= next_tag;
                  count_ff <= next_st.count;
                  valid_ff <= next_st.valid;
               end
            end
            OP_APPEND: begin
               // first free cell of the packed prefix
               if (!valid_ff && prev_valid) begin
                  tag_ff   <= cmd_tag;
                  count_ff <= cmd.amount;
                  valid_ff <= 1'b1;
               end
            end
            OP_CLEAR: begin
               valid_ff <= 1'b0;
               hit_ff   <= 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

FILE: rtl/refcounted_tag_set.sv
// Reference-counted tag set: a chain of CAPACITY cells holds distinct tags with 8-bit
// counts as a packed prefix. A request passes the states S_IDLE, in which it is accepted
// and its word registered, S_LOOK, in which every cell compares its tag, and S_APPLY, in
// which the control applies the update and loads the result register; a new word is
// accepted only once the last one is through and the control is back in S_IDLE;
// a delete moves all later entries down one place in the apply cycle, rippling along the
// cell chain. req ready is high while no request is in flight, so the next word may be
// accepted while a finished result still waits in the output register; the apply cycle
// waits only while that register is still full. Reset empties the table.
// depends on rcts_pkg, rcts_req_if, rcts_rsp_if, rcts_cell
module refcounted_tag_set import rcts_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int TAG_BITS = TAG_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   rcts_req_if.sink   req_in,
   rcts_rsp_if.source rsp_out
);

   localparam int TW    = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {S_IDLE, S_LOOK, S_APPLY} state_type;

   state_type             state_ff;
   logic [REQ_W-1:0]      req_type_ff;
   logic [TW-1:0]         tag_ff;
   logic [COUNT_W-1:0]    amount_ff;
   logic [CNT_W-1:0]      occ_ff;
   logic                  rsp_valid_ff;
   logic                  found_ff;
   logic [COUNT_W-1:0]    ref_count_ff;
   logic [CNT_W-1:0]      rsp_occ_ff;
   logic [STATUS_W-1:0]   status_ff;

   cell_cmd_type          cmd;
   logic [TW-1:0]         cell_tag [CAPACITY];
   cell_state_type        cell_st  [CAPACITY];
   logic                  shift_chain [CAPACITY+1];

   logic                  any_hit;
   logic [COUNT_W-1:0]    hit_count;
   logic [COUNT_W:0]      sum_wide;
   logic [COUNT_W-1:0]    diff;
   logic                  go;
   cell_op_type           apply_op;
   logic                  found_in;
   logic [COUNT_W-1:0]    ref_count_in;
   logic [CNT_W-1:0]      occ_in;
   status_code_type       status_in;

   assign shift_chain[0] = 1'b0;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic [TW-1:0]   nxt_tag;
         cell_state_type  nxt_st;
         logic            prv_valid;

         if (g == CAPACITY - 1) begin : g_last
            assign nxt_tag = '0;
            assign nxt_st  = '0;
         end else begin : g_mid
            assign nxt_tag = cell_tag[g+1];
            assign nxt_st  = cell_st[g+1];
         end

         if (g == 0) begin : g_first
            assign prv_valid = 1'b1;
         end else begin : g_rest
            assign prv_valid = cell_st[g-1].valid;
         end

         rcts_cell #(.TW(TW)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .cmd_tag    (tag_ff),
            .prev_valid (prv_valid),
            .next_tag   (nxt_tag),
            .next_st    (nxt_st),
            .shift_in   (shift_chain[g]),
            .shift_out  (shift_chain[g+1]),
            .own_tag    (cell_tag[g]),
            .own_st     (cell_st[g])
         );
      end
   endgenerate

   // tags are distinct, so at most one cell hits
   always_comb begin
      any_hit   = 1'b0;
      hit_count = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         any_hit   = any_hit | cell_st[i].hit;
         hit_count = hit_count | (cell_st[i].hit ? cell_st[i].count : '0);
      end
   end

   assign sum_wide = {1'b0, hit_count} + {1'b0, amount_ff};
   assign diff     = hit_count - amount_ff;

   always_comb begin
      apply_op     = OP_NONE;
      found_in     = any_hit;
      ref_count_in = any_hit ? hit_count : '0;
      occ_in       = occ_ff;
      status_in    = ST_OK;
      case (req_code_type'(req_type_ff))
         REQ_ADD: begin
            if (amount_ff != '0) begin
               if (any_hit) begin
                  if (sum_wide[COUNT_W]) begin
                     status_in = ST_OVER;
                  end else begin
                     apply_op     = OP_ADD;
                     ref_count_in = sum_wide[COUNT_W-1:0];
                  end
               end else if (occ_ff == CNT_W'(CAPACITY)) begin
                  status_in = ST_FULL;
               end else begin
                  apply_op     = OP_APPEND;
                  found_in     = 1'b1;
                  ref_count_in = amount_ff;
                  occ_in       = occ_ff + CNT_W'(1);
               end
            end
         end
         REQ_REMOVE: begin
            if (!any_hit) begin
               status_in = ST_ABSENT;
            end else if (amount_ff > hit_count) begin
               status_in = ST_UNDER;
            end else if (amount_ff != '0) begin
               if (diff == '0) begin
                  apply_op     = OP_DEL;
                  found_in     = 1'b0;
                  ref_count_in = '0;
                  occ_in       = occ_ff - CNT_W'(1);
               end else begin
                  apply_op     = OP_SUB;
                  ref_count_in = diff;
               end
            end
         end
         REQ_CLEAR: begin
            apply_op     = OP_CLEAR;
            found_in     = 1'b0;
            ref_count_in = '0;
            occ_in       = '0;
         end
         REQ_LOOKUP: begin
         end
         default: begin
         end
      endcase
   end

   // apply only when the result register is free or being emptied
   assign go = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_out.ready);

   always_comb begin
      cmd.amount = amount_ff;
      case (state_ff)
         S_LOOK:  cmd.op = OP_LOOK;
         S_APPLY: cmd.op = go ? apply_op : OP_NONE;
         default: cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_out.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_in.valid) begin
                  req_type_ff <= req_in.req_type;
                  tag_ff      <= req_in.tag[TW-1:0];
                  amount_ff   <= req_in.amount;
                  state_ff    <= S_LOOK;
               end
            end
            S_LOOK: begin
               state_ff <= S_APPLY;
            end
            S_APPLY: begin
               if (go) begin
                  occ_ff       <= occ_in;
                  found_ff     <= found_in;
                  ref_count_ff <= ref_count_in;
                  rsp_occ_ff   <= occ_in;
                  status_ff    <= status_in;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_in.ready      = (state_ff == S_IDLE);
   assign rsp_out.valid     = rsp_valid_ff;
   assign rsp_out.found     = found_ff;
   assign rsp_out.ref_count = ref_count_ff;
   assign rsp_out.occupancy = OCC_W'(rsp_occ_ff);
   assign rsp_out.status    = status_ff;

endmodule
